### src/sha_pkg.sv
// Shared types, constants and functions for the SHA-256 message hasher.
package sha_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned CountWidth = 61;
    localparam int unsigned FillWidth  = 6;
    localparam int unsigned RoundWidth = 6;

    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [WordWidth-1:0] t_word;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic       take_beat;   // pack the input beat into the buffer
        logic       pad_start;   // write the 0x80 marker at the fill point
        logic       pad_zero;    // fill the rest of the block with zeros
        logic       put_length;  // write the bit length into words 14 and 15
        logic       comp_start;  // load schedule and working variables
        logic       comp_round;  // run one compression round
        logic       comp_final;  // add working variables into the hash
        logic       hash_reset;  // restore the initial hash and clear counters
    } t_dp_cmd;

    // Datapath status returned to the controller
    typedef struct packed {
        logic [FillWidth:0]  fill_after;  // fill level after the pending beat
        logic [FillWidth-1:0] fill_level;
        logic [RoundWidth-1:0] round;
    } t_dp_stat;

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage

### src/sha_datapath.sv
// Datapath: block buffer, message schedule, round logic and hash state.
module sha_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha_pkg::t_dp_cmd     i_cmd,
    input  logic [31:0]          i_data_word,
    input  logic [2:0]           i_valid_bytes,
    input  logic [2:0]           i_out_index,
    output sha_pkg::t_dp_stat    o_stat,
    output logic [31:0]          o_hash_word
);
    import sha_pkg::*;

    t_word r_buf   [16];
    t_word r_sched [16];
    t_word r_var   [8];
    t_word r_hash  [8];
    t_word r_carry;
    logic [CountWidth-1:0] r_count;
    logic [FillWidth-1:0]  r_fill;
    logic [RoundWidth-1:0] r_round;

    logic [2:0]           nb;
    logic [FillWidth:0]   fill_after;
    logic [63:0]          bits;
    t_word w, w15, w2, s0x, s1x, t1, t2, sig0, sig1, ch, mj;

    // Clamp the byte count at four
    assign nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
    assign fill_after = {1'b0, r_fill} + {4'd0, nb};
    assign bits = {r_count, 3'b000};

    // Schedule word for this round
    always_comb begin
        w15 = r_sched[4'(r_round - 6'd15)];
        w2  = r_sched[4'(r_round - 6'd2)];
        s0x = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1x = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        if (r_round < 6'd16) begin
            w = r_sched[r_round[3:0]];
        end else begin
            w = r_sched[r_round[3:0]] + s0x + r_sched[4'(r_round - 6'd7)] + s1x;
        end
        sig1 = rotr(r_var[4], 6) ^ rotr(r_var[4], 11) ^ rotr(r_var[4], 25);
        ch   = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
        t1   = r_var[7] + sig1 + ch + RoundK[r_round] + w;
        sig0 = rotr(r_var[0], 2) ^ rotr(r_var[0], 13) ^ rotr(r_var[0], 22);
        mj   = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
        t2   = sig0 + mj;
    end

    // Block buffer writes; bytes past the block end wait in the carry word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_beat) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < nb) begin
                    logic [FillWidth:0] p;
                    p = {1'b0, r_fill} + 7'(i);
                    if (p[FillWidth]) begin
                        r_carry[8*(3-p[1:0]) +: 8] <= i_data_word[8*(3-i) +: 8];
                    end else begin
                        r_buf[p[5:2]][8*(3-p[1:0]) +: 8] <= i_data_word[8*(3-i) +: 8];
                    end
                end
            end
        end else if (i_cmd.pad_start) begin
            r_buf[r_fill[5:2]][8*(3-r_fill[1:0]) +: 8] <= PadByte;
        end else if (i_cmd.pad_zero) begin
            for (int i = 0; i < 64; i++) begin
                if (FillWidth'(i) >= r_fill) begin
                    r_buf[i/4][8*(3-(i%4)) +: 8] <= 8'h00;
                end
            end
        end else if (i_cmd.put_length) begin
            r_buf[14] <= bits[63:32];
            r_buf[15] <= bits[31:0];
        end else if (i_cmd.comp_start) begin
            // Move carried bytes to the head of the next block
            r_buf[0] <= r_carry;
        end
    end

    // Schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_sched <= r_buf;
            r_var   <= r_hash;
        end else if (i_cmd.comp_round) begin
            r_sched[r_round[3:0]] <= w;
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= t1 + t2;
        end
    end

    // Hash state, counters and round index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hash_reset) begin
            r_hash  <= InitHash;
            r_count <= '0;
            r_fill  <= '0;
            r_round <= '0;
        end else begin
            if (i_cmd.take_beat) begin
                r_count <= r_count + CountWidth'(nb);
                r_fill  <= fill_after[FillWidth-1:0];
            end
            if (i_cmd.pad_start) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.pad_zero) begin
                r_fill <= '0;
            end
            if (i_cmd.comp_start) begin
                r_round <= '0;
            end else if (i_cmd.comp_round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.comp_final) begin
                for (int j = 0; j < 8; j++) begin
                    r_hash[j] <= r_hash[j] + r_var[j];
                end
            end
        end
    end

    assign o_stat.fill_after = fill_after;
    assign o_stat.fill_level = r_fill;
    assign o_stat.round      = r_round;
    assign o_hash_word       = r_hash[i_out_index];

endmodule

### src/sha_control.sv
// Controller: sequences intake, padding, compression and digest output.
module sha_control (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_last_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_out_index,
    input  sha_pkg::t_dp_stat    i_stat,
    output sha_pkg::t_dp_cmd     o_cmd
);
    import sha_pkg::*;

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StPad    = 3'd1;
    localparam logic [2:0] StZero   = 3'd2;
    localparam logic [2:0] StLength = 3'd3;
    localparam logic [2:0] StLoad   = 3'd4;
    localparam logic [2:0] StRound  = 3'd5;
    localparam logic [2:0] StFinal  = 3'd6;
    localparam logic [2:0] StOut    = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;     // message end pending
    logic       r_padded, n_padded; // length block is in the buffer
    logic       r_pad_done, n_pad_done;
    logic [2:0] r_idx, n_idx;
    logic       accept;

    assign o_in_stall  = (r_state != StIdle);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == StOut);
    assign o_out_index = r_idx;

    // Next state and command decode
    always_comb begin
        n_state  = r_state;
        n_last   = r_last;
        n_padded = r_padded;
        n_idx    = r_idx;
        o_cmd    = '0;
        unique case (r_state)
            StIdle: begin
                if (accept) begin
                    o_cmd.take_beat = 1'b1;
                    n_last   = i_last_word;
                    n_padded = 1'b0;
                    if (i_stat.fill_after[FillWidth]) begin
                        n_state = StLoad;
                    end else if (i_last_word) begin
                        n_state = StPad;
                    end
                end
            end
            StPad: begin
                // Marker in the last byte fills the block: compress it as is
                o_cmd.pad_start = 1'b1;
                n_state = (i_stat.fill_level == 6'd63) ? StLoad : StZero;
            end
            StZero: begin
                // Zeros up to the end; length overwrites words 14 and 15 if it fits
                o_cmd.pad_zero = 1'b1;
                n_state = (i_stat.fill_level > 6'd56) ? StLoad : StLength;
            end
            StLength: begin
                o_cmd.put_length = 1'b1;
                n_padded = 1'b1;
                n_state  = StLoad;
            end
            StLoad: begin
                o_cmd.comp_start = 1'b1;
                n_state = StRound;
            end
            StRound: begin
                o_cmd.comp_round = 1'b1;
                if (i_stat.round == 6'd63) begin
                    n_state = StFinal;
                end
            end
            StFinal: begin
                o_cmd.comp_final = 1'b1;
                if (!r_last) begin
                    n_state = StIdle;
                end else if (r_padded) begin
                    n_idx   = '0;
                    n_state = StOut;
                end else begin
                    // Block went out before the length: pad or zero-fill next
                    n_state = r_pad_done ? StZero : StPad;
                end
            end
            StOut: begin
                if (!i_out_stall) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.hash_reset = 1'b1;
                        n_state = StIdle;
                    end
                end
            end
            default: n_state = StIdle;
        endcase
    end

    // Track whether the 0x80 marker has been written
    always_comb begin
        n_pad_done = r_pad_done;
        if (r_state == StIdle) begin
            n_pad_done = 1'b0;
        end else if (r_state == StPad) begin
            n_pad_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= StIdle;
            r_last     <= 1'b0;
            r_padded   <= 1'b0;
            r_idx      <= '0;
            r_pad_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_last     <= n_last;
            r_padded   <= n_padded;
            r_idx      <= n_idx;
            r_pad_done <= n_pad_done;
        end
    end

`ifndef SYNTHESIS
    a_out_only_after_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StOut) |-> r_padded)
        else $error("digest shown before length block");
    a_round_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StRound && i_stat.round == 6'd63) |=> (r_state == StFinal))
        else $error("round count did not end compression");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_beat |-> (r_state == StIdle))
        else $error("beat taken while busy");
`endif

endmodule

### src/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher.
// Takes message beats while idle; each beat packs up to four bytes.
// Completing a 64-byte block runs the compression loop, one round per cycle
// (load, 64 rounds, hash update), during which input stalls. A last beat adds
// padding and one or two compressions, then eight digest beats, one per
// cycle unless the output stalls.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest
);
    import sha_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [2:0] idx;

    sha_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_last_word(i_last_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_index(idx), .i_stat(stat), .o_cmd(cmd)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_data_word(i_data_word), .i_valid_bytes(i_valid_bytes),
        .i_out_index(idx), .o_stat(stat), .o_hash_word(o_digest_word)
    );

    assign o_word_index  = idx;
    assign o_last_digest = (idx == 3'd7);

endmodule
